>>> src/assert_macros.svh
// Assertion helpers for the RTL files (used by r2fft_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define R2_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define R2_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/r2fft_pkg.sv
package r2fft_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int OUT_BITS = 27;
	localparam int INDEX_BITS = 10;
	localparam int MAX_WORD_BITS = 35;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_link_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH_RD,
		ST_FETCH_OUT,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_SUM,
		ST_BF_WA,
		ST_BF_WB
	} back_state_t;

	// Q30 quarter-wave value to Q1.(tb-1), round half up, saturate +1.0.
	function automatic logic signed [63:0] tw_quant(input logic signed [63:0] q30,
			input int unsigned tb);
		logic signed [63:0] v;
		logic signed [63:0] q;
		logic signed [63:0] top;
		int unsigned sh;
		sh = 31 - tb;
		top = (64'sd1 <<< (tb - 1)) - 64'sd1;
		v = q30;
		if (v < 0)
			v = 0;
		if (v > (64'sd1 <<< 30))
			v = 64'sd1 <<< 30;
		q = (v + (64'sd1 <<< (sh - 1))) >>> sh;
		return (q > top) ? top : q;
	endfunction

	// Twiddle entry k of a 2^logp point transform: {cos[31:0], sin[31:0]}.
	function automatic logic [63:0] tw_entry(input int unsigned k, input int unsigned logp,
			input int unsigned tb);
		logic [63:0] a;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] ts;
		logic [63:0] tc;
		logic signed [63:0] ss;
		logic signed [63:0] cc;
		logic signed [63:0] qs;
		logic signed [63:0] qc;
		int unsigned quarter;
		quarter = (1 << logp) >> 2;
		a = (k <= quarter) ? 64'(k) : 64'((quarter << 1) - k);
		x = (a * PI_Q30 * 64'd2) >> logp;
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		ss = signed'(x);
		cc = signed'(tc);
		for (int n = 1; n <= 12; n++) begin
			ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				ss = ss - signed'(ts);
				cc = cc - signed'(tc);
			end else begin
				ss = ss + signed'(ts);
				cc = cc + signed'(tc);
			end
		end
		qs = tw_quant(ss, tb);
		qc = tw_quant(cc, tb);
		if (k > quarter)
			qc = -qc;
		return {qc[31:0], qs[31:0]};
	endfunction

endpackage

>>> src/r2fft_ifs.sv
interface r2fft_in_if import r2fft_pkg::*; ();
	logic valid;
	logic ready;
	logic mode;
	logic signed [SAMPLE_BITS-1:0] in_real;
	logic signed [SAMPLE_BITS-1:0] in_imag;

	modport source (output valid, output mode, output in_real, output in_imag, input ready);
	modport sink (input valid, input mode, input in_real, input in_imag, output ready);
endinterface

interface r2fft_out_if import r2fft_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [OUT_BITS-1:0] out_real;
	logic signed [OUT_BITS-1:0] out_imag;
	logic [INDEX_BITS-1:0] out_index;
	logic out_last;
	logic out_valid;

	modport source (output valid, output out_real, output out_imag, output out_index,
		output out_last, output out_valid, input ready);
	modport sink (input valid, input out_real, input out_imag, input out_index,
		input out_last, input out_valid, output ready);
endinterface

>>> src/radix2_complex_fft.sv
// Iterative radix-2 decimation-in-time FFT over a POINTS-sample complex frame.
// Send words with mode 0 to load samples in natural order; each load is written
// to the frame memory at its bit-reversed address, so no separate reorder pass
// is needed. The load that completes the frame starts the transform: log2(POINTS)
// stages of POINTS/2 butterflies on one shared butterfly unit, each run as: read
// a and b, multiply, add with rounding and saturation, write a, write b, because
// the frame memory has one write port. The input keeps accepting into a two-word
// queue meanwhile and then holds off. Send words with mode 1 to fetch results in
// index order; a fetch with no pending frame returns one word with out_valid low
// and zero fields. A load while results are unread drops them and starts a new
// frame. inverse_mode is sampled when the transform starts: 1 uses conjugate
// twiddles and divides by POINTS with round-to-nearest on the way out.
module radix2_complex_fft import r2fft_pkg::*; #(
	parameter int POINTS = 1024,
	parameter int TWIDDLE_BITS = 18
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic cfg_wr_data,
	r2fft_in_if.sink in_ch,
	r2fft_out_if.source out_ch
);

	// configuration register
	logic inverse_mode_q;

	// queue head and pop strobe between front and back
	q_link_t link;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inverse_mode_q <= 1'b0;
		else if (cfg_wr_en)
			inverse_mode_q <= cfg_wr_data;
	end

	// front: take words, classify load vs fetch, queue them
	r2fft_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.link(link),
		.pop(pop)
	);

	// back: frame memory, butterfly sequencer, result register
	r2fft_back #(
		.POINTS(POINTS),
		.TWIDDLE_BITS(TWIDDLE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.inverse_mode(inverse_mode_q),
		.link(link),
		.pop(pop),
		.res(out_ch)
	);

endmodule

>>> src/r2fft_ram.sv
module r2fft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0] rdata0,
	input logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

>>> src/r2fft_front.sv
module r2fft_front import r2fft_pkg::*; (
	input logic clk,
	input logic arst_n,
	r2fft_in_if.sink in_ch,
	output q_link_t link,
	input logic pop
);

	cmd_t entry_q [QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	cmd_t cmd_in;

	// classify the incoming word
	always_comb begin
		cmd_in.kind = in_ch.mode ? CMD_FETCH : CMD_LOAD;
		cmd_in.re = in_ch.in_real;
		cmd_in.im = in_ch.in_imag;
	end

	assign in_ch.ready = (count_q != 2'(QUEUE_DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign link.valid = (count_q != 2'd0);
	assign link.cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop && link.valid)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop && link.valid);
		end
	end

endmodule

>>> src/r2fft_back.sv
`include "assert_macros.svh"

module r2fft_back import r2fft_pkg::*; #(
	parameter int POINTS = 1024,
	parameter int TWIDDLE_BITS = 18
) (
	input logic clk,
	input logic arst_n,
	input logic inverse_mode,
	input q_link_t link,
	output logic pop,
	r2fft_out_if.source res
);

	localparam int LOGP = $clog2(POINTS);
	localparam int AW = LOGP;
	localparam int HW = LOGP - 1;
	localparam int SW = $clog2(LOGP);
	localparam int WB_RAW = SAMPLE_BITS + LOGP + 1;
	localparam int WB = (WB_RAW > MAX_WORD_BITS) ? MAX_WORD_BITS : WB_RAW;
	localparam int TB = TWIDDLE_BITS;
	localparam int PW = WB + TB + 2;
	localparam int RW = WB + 2;
	localparam int SUMW = WB + 3;
	localparam int XW = MAX_WORD_BITS + 2;
	localparam int IXW = (AW > INDEX_BITS) ? AW : INDEX_BITS;
	localparam logic signed [SUMW-1:0] WORD_MAX = SUMW'((64'sd1 <<< (WB - 1)) - 64'sd1);
	localparam logic signed [SUMW-1:0] WORD_MIN = -WORD_MAX - SUMW'(1);

	function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
		logic [AW-1:0] r;
		for (int i = 0; i < AW; i++)
			r[i] = v[AW-1-i];
		return r;
	endfunction

	function automatic logic signed [WB-1:0] sat_word(input logic signed [SUMW-1:0] v);
		logic signed [SUMW-1:0] c;
		c = v;
		if (v > WORD_MAX)
			c = WORD_MAX;
		if (v < WORD_MIN)
			c = WORD_MIN;
		return c[WB-1:0];
	endfunction

	// twiddle ROM, built at elaboration
	logic [2*TB-1:0] tw_rom [POINTS/2];
	for (genvar g = 0; g < POINTS / 2; g++) begin : g_tw
		localparam logic [63:0] ENTRY = tw_entry(g, LOGP, TB);
		assign tw_rom[g] = {ENTRY[32+TB-1:32], ENTRY[TB-1:0]};
	end

	back_state_t state_q, state_d;
	logic [AW-1:0] load_cnt_q;
	logic [AW-1:0] read_cnt_q;
	logic ready_q;
	logic inv_run_q;
	logic [SW-1:0] stage_q;
	logic [HW-1:0] bfi_q;
	logic [AW-1:0] a_q, b_q;
	logic [2*TB-1:0] tw_q;

	logic [AW-1:0] load_addr;
	logic [AW-1:0] half_v, mask_v, bfi_ext, a_c, b_c, w_full;
	logic [HW-1:0] w_c;
	logic ram_we;
	logic [AW-1:0] ram_waddr, raddr0;
	logic [2*WB-1:0] ram_wdata, rdata0, rdata1;
	logic out_load;
	logic bf_done;

	// butterfly datapath
	logic signed [TB-1:0] wr, ws;
	logic signed [TB:0] wi;
	logic signed [WB-1:0] br, bi;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic [2*WB-1:0] a_s1;
	logic signed [PW-1:0] tr_full, ti_full;
	logic signed [RW-1:0] tr, ti;
	logic signed [WB-1:0] ar, ai;
	logic [2*WB-1:0] sum_a_s2, sum_b_s2;

	// fetch datapath
	logic signed [WB-1:0] fr, fi;
	logic signed [WB:0] fr_sc, fi_sc, fr_v, fi_v;
	logic signed [XW-1:0] fr_x, fi_x;
	logic [IXW-1:0] idx_x;

	assign load_addr = ready_q ? '0 : load_cnt_q;
	assign half_v = AW'(1) << stage_q;
	assign mask_v = half_v - AW'(1);
	assign bfi_ext = AW'(bfi_q);
	assign a_c = ((bfi_ext & ~mask_v) << 1) | (bfi_ext & mask_v);
	assign b_c = a_c | half_v;
	assign w_full = (bfi_ext & mask_v) << (SW'(LOGP - 1) - stage_q);
	assign w_c = w_full[HW-1:0];
	assign bf_done = (&bfi_q) && (stage_q == SW'(LOGP - 1));
	assign raddr0 = (state_q == ST_BF_RD) ? a_c : read_cnt_q;

	r2fft_ram #(
		.WIDTH(2 * WB),
		.DEPTH(POINTS)
	) u_frame (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr0(raddr0),
		.rdata0(rdata0),
		.raddr1(b_c),
		.rdata1(rdata1)
	);

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		ram_we = 1'b0;
		ram_waddr = a_q;
		ram_wdata = sum_a_s2;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (link.valid) begin
					pop = 1'b1;
					if (link.cmd.kind == CMD_LOAD) begin
						ram_we = 1'b1;
						ram_waddr = bitrev(load_addr);
						ram_wdata = {WB'(link.cmd.re), WB'(link.cmd.im)};
						if (load_addr == AW'(POINTS - 1))
							state_d = ST_BF_RD;
					end else if (ready_q) begin
						state_d = ST_FETCH_RD;
					end else begin
						state_d = ST_FETCH_OUT;
					end
				end
			end
			ST_FETCH_RD: state_d = ST_FETCH_OUT;
			ST_FETCH_OUT: begin
				if (!res.valid || res.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_BF_RD: state_d = ST_BF_MUL;
			ST_BF_MUL: state_d = ST_BF_SUM;
			ST_BF_SUM: state_d = ST_BF_WA;
			ST_BF_WA: begin
				ram_we = 1'b1;
				state_d = ST_BF_WB;
			end
			ST_BF_WB: begin
				ram_we = 1'b1;
				ram_waddr = b_q;
				ram_wdata = sum_b_s2;
				state_d = bf_done ? ST_IDLE : ST_BF_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wr = tw_q[2*TB-1:TB];
		ws = tw_q[TB-1:0];
		wi = inv_run_q ? -(TB+1)'(ws) : (TB+1)'(ws);
		br = rdata1[2*WB-1:WB];
		bi = rdata1[WB-1:0];
		tr_full = p_rr_s1 - p_ii_s1;
		ti_full = p_ri_s1 + p_ir_s1;
		tr = RW'((tr_full + PW'(64'sd1 <<< (TB - 2))) >>> (TB - 1));
		ti = RW'((ti_full + PW'(64'sd1 <<< (TB - 2))) >>> (TB - 1));
		ar = a_s1[2*WB-1:WB];
		ai = a_s1[WB-1:0];
	end

	always_ff @(posedge clk) begin
		tw_q <= tw_rom[w_c];
		p_rr_s1 <= PW'(wr * br);
		p_ii_s1 <= PW'(wi * bi);
		p_ri_s1 <= PW'(wr * bi);
		p_ir_s1 <= PW'(wi * br);
		a_s1 <= rdata0;
		// hold both sums until the b write; a_s1 moves on after the sum cycle
		if (state_q == ST_BF_SUM) begin
			sum_a_s2 <= {sat_word(SUMW'(ar) + SUMW'(tr)), sat_word(SUMW'(ai) + SUMW'(ti))};
			sum_b_s2 <= {sat_word(SUMW'(ar) - SUMW'(tr)), sat_word(SUMW'(ai) - SUMW'(ti))};
		end
		if (state_q == ST_BF_RD) begin
			a_q <= a_c;
			b_q <= b_c;
		end
	end

	// result word: inverse scaling rounds to nearest
	always_comb begin
		fr = rdata0[2*WB-1:WB];
		fi = rdata0[WB-1:0];
		fr_sc = ((WB+1)'(fr) + (WB+1)'(POINTS / 2)) >>> LOGP;
		fi_sc = ((WB+1)'(fi) + (WB+1)'(POINTS / 2)) >>> LOGP;
		fr_v = inv_run_q ? fr_sc : (WB+1)'(fr);
		fi_v = inv_run_q ? fi_sc : (WB+1)'(fi);
		fr_x = XW'(fr_v);
		fi_x = XW'(fi_v);
		idx_x = IXW'(read_cnt_q);
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res.out_real <= ready_q ? fr_x[OUT_BITS-1:0] : '0;
			res.out_imag <= ready_q ? fi_x[OUT_BITS-1:0] : '0;
			res.out_index <= ready_q ? idx_x[INDEX_BITS-1:0] : '0;
			res.out_last <= ready_q && (read_cnt_q == AW'(POINTS - 1));
			res.out_valid <= ready_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			load_cnt_q <= '0;
			read_cnt_q <= '0;
			ready_q <= 1'b0;
			inv_run_q <= 1'b0;
			stage_q <= '0;
			bfi_q <= '0;
			res.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				res.valid <= 1'b1;
			else if (res.ready)
				res.valid <= 1'b0;
			if (state_q == ST_IDLE && link.valid && link.cmd.kind == CMD_LOAD) begin
				if (ready_q) begin
					ready_q <= 1'b0;
					read_cnt_q <= '0;
				end
				if (load_addr == AW'(POINTS - 1)) begin
					load_cnt_q <= '0;
					inv_run_q <= inverse_mode;
					stage_q <= '0;
					bfi_q <= '0;
				end else begin
					load_cnt_q <= load_addr + AW'(1);
				end
			end
			if (out_load && ready_q) begin
				read_cnt_q <= read_cnt_q + AW'(1);
				if (read_cnt_q == AW'(POINTS - 1))
					ready_q <= 1'b0;
			end
			if (state_q == ST_BF_WB) begin
				bfi_q <= bfi_q + HW'(1);
				if (&bfi_q)
					stage_q <= stage_q + SW'(1);
				if (bf_done) begin
					ready_q <= 1'b1;
					read_cnt_q <= '0;
				end
			end
		end
	end

	`R2_ASSERT_NXT(a_bf_pair, clk, arst_n, state_q == ST_BF_WA, ram_waddr == ($past(ram_waddr) | half_v), "butterfly b write not a|half")
	`R2_ASSERT_IMP(a_bf_no_res, clk, arst_n, state_q == ST_BF_RD || state_q == ST_BF_MUL || state_q == ST_BF_SUM || state_q == ST_BF_WA || state_q == ST_BF_WB, !ready_q, "results flagged during transform")
	`R2_ASSERT_NXT(a_last_clr, clk, arst_n, out_load && ready_q && read_cnt_q == AW'(POINTS - 1), !ready_q && read_cnt_q == '0, "frame not retired after last result")

endmodule
